// File: sv/lzfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the LZF tile decompressor.
// No dependencies; used by lzf_decompressor_top.
package lzfd_pkg;

   localparam int HISTORY_DEPTH    = 8192;
   localparam int HIST_AW          = $clog2(HISTORY_DEPTH);
   localparam int MAX_TILE_BYTES   = 65536;
   localparam int BYTES_PER_RESULT = 8;
   localparam int LANE_W           = $clog2(BYTES_PER_RESULT);
   localparam int COUNT_W          = 17;
   localparam int LEN_W            = 9;

   localparam logic [COUNT_W-1:0] TILE_BYTES_RESET = COUNT_W'(16384);
   localparam logic [COUNT_W-1:0] TILE_LIMIT_MAX   = COUNT_W'(MAX_TILE_BYTES);

   // Token format
   localparam logic [7:0] LIT_CTRL_LIMIT = 8'd32;
   localparam logic [2:0] EXT_LEN_CODE   = 3'd7;
   localparam logic [7:0] OFF_HIGH_MASK  = 8'h1f;
   localparam int         MIN_REF_LEN    = 2;

   // Closing status codes
   localparam logic [1:0] STATUS_COMPLETE   = 2'd0;
   localparam logic [1:0] STATUS_SHORT      = 2'd1;
   localparam logic [1:0] STATUS_BAD_OFFSET = 2'd2;

   typedef enum logic [1:0] {
      PH_CTRL,
      PH_LIT,
      PH_EXT,
      PH_OFF
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [63:0]        out_bytes;
      logic [3:0]         byte_count;
      logic               run_last;
      logic               tile_done;
      logic [1:0]         status;
      logic [COUNT_W-1:0] produced;
   } rsp_type;

endpackage

// File: sv/lzfd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Same-address write and read return the new data. No dependencies.
module lzfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lzf_decompressor_top.sv
`timescale 1ns / 1ps
// Top level of the LZF tile decompressor: token decoder, history copy engine
// and result register. Depends on lzfd_pkg and lzfd_ram.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_data) carries one compressed
//    byte per request; last_byte marks the final byte of a tile.
//  - Result channel (rsp_valid / rsp_stall / rsp_data) returns up to eight
//    decompressed bytes per result, earliest byte in the lowest lane, plus a
//    closing result (tile_done) with status and produced count per tile.
//  - csr_wr_en / csr_wr_data set the tile size; write only while idle.
// Flow:
//  - Control, extension and non-final literal bytes are taken without leaving idle.
//  - A completed literal run or a back reference of N output bytes goes
//    through the copy engine: one byte per cycle, unless frozen by a waiting
//    flush, through the single read port of the 8192-byte history RAM, whose
//    read data is registered. The closing result is sent from a close state.
// req_stall is high while the copy engine runs or a closing result is queued.
// When rsp_stall holds a full result register while a result waits to flush,
// the copy engine freezes until the result is taken; no result is lost or repeated.
// Reset (synchronous, active high) returns the decoder to expect a control
// byte, clears the counters and sets the tile size to 16384. The history RAM
// is not cleared: reads only ever reach bytes written earlier in the tile.
module lzf_decompressor_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lzfd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lzfd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [lzfd_pkg::COUNT_W-1:0]        csr_wr_data
);

   // Configuration: effective limit, already clipped to the maximum tile size
   logic [lzfd_pkg::COUNT_W-1:0] lim_ff, lim_in;

   // Decoder state
   lzfd_pkg::state_type          state_ff, state_in;
   lzfd_pkg::phase_type          phase_ff, phase_in;
   logic [5:0]                   run_len_ff, run_len_in;
   logic [5:0]                   literal_left_ff, literal_left_in;
   logic [lzfd_pkg::LEN_W-1:0]   ref_length_ff, ref_length_in;
   logic [4:0]                   off_high_ff, off_high_in;
   logic [lzfd_pkg::COUNT_W-1:0] oc_ff, oc_in;
   logic                         halted_ff, halted_in;
   logic                         last_ff, last_in;

   // Copy engine
   logic [lzfd_pkg::HIST_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lzfd_pkg::LEN_W-1:0]   iss_left_ff, iss_left_in;
   logic [lzfd_pkg::COUNT_W-1:0] iss_pos_ff, iss_pos_in;
   logic                         rv_ff, rv_in;
   logic [63:0]                  pack_ff, pack_in;
   logic [lzfd_pkg::LANE_W-1:0]  pack_cnt_ff, pack_cnt_in;
   logic [63:0]                  pack_word;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   lzfd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   // History RAM port
   logic                         hist_we;
   logic [lzfd_pkg::HIST_AW-1:0] hist_wa;
   logic [7:0]                   hist_wd;
   logic                         hist_re;
   logic [7:0]                   hist_rd;

   logic                         req_accept;
   logic                         consume;
   logic                         out_free;
   logic                         issue;
   logic                         w_flush;
   logic                         go;
   logic                         copy_start;
   logic [4:0]                   lit_idx;
   logic [12:0]                  off_raw;

   lzfd_ram #(
      .WIDTH (8),
      .DEPTH (lzfd_pkg::HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wa),
      .wr_data (hist_wd),
      .rd_en   (hist_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (hist_rd)
   );

   assign req_stall  = (state_ff != lzfd_pkg::ST_IDLE);
   assign req_accept = req_valid && (state_ff == lzfd_pkg::ST_IDLE);
   // Ignore bytes once the tile is halted or its output is full
   assign consume    = !halted_ff && (oc_ff < lim_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // Issue a history read while bytes remain and the limit is not reached
   assign issue      = (iss_left_ff != '0) && (iss_pos_ff < lim_ff);
   // Flush the packed word when it fills or the item's last byte lands
   assign w_flush    = (pack_cnt_ff == lzfd_pkg::LANE_W'(lzfd_pkg::BYTES_PER_RESULT - 1))
                       || !issue;
   // Freeze the engine while a flush waits for the result register
   assign go         = !(rv_ff && w_flush && !out_free);
   assign lit_idx    = 5'(run_len_ff - literal_left_ff);
   assign off_raw    = {off_high_ff, req_data.in_byte};

   // Drop the returning byte into its lane; clear lanes above it
   always_comb begin
      for (int j = 0; j < lzfd_pkg::BYTES_PER_RESULT; j++) begin
         if (lzfd_pkg::LANE_W'(j) == pack_cnt_ff) begin
            pack_word[8*j +: 8] = hist_rd;
         end else if (lzfd_pkg::LANE_W'(j) < pack_cnt_ff) begin
            pack_word[8*j +: 8] = pack_ff[8*j +: 8];
         end else begin
            pack_word[8*j +: 8] = 8'd0;
         end
      end
   end

   always_comb begin
      lim_in          = lim_ff;
      state_in        = state_ff;
      phase_in        = phase_ff;
      run_len_in      = run_len_ff;
      literal_left_in = literal_left_ff;
      ref_length_in   = ref_length_ff;
      off_high_in     = off_high_ff;
      oc_in           = oc_ff;
      halted_in       = halted_ff;
      last_in         = last_ff;
      rd_ptr_in       = rd_ptr_ff;
      iss_left_in     = iss_left_ff;
      iss_pos_in      = iss_pos_ff;
      rv_in           = rv_ff;
      pack_in         = pack_ff;
      pack_cnt_in     = pack_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      hist_we         = 1'b0;
      hist_wa         = oc_ff[lzfd_pkg::HIST_AW-1:0];
      hist_wd         = hist_rd;
      hist_re         = 1'b0;
      copy_start      = 1'b0;

      if (csr_wr_en) begin
         lim_in = (csr_wr_data > lzfd_pkg::TILE_LIMIT_MAX) ? lzfd_pkg::TILE_LIMIT_MAX
                                                           : csr_wr_data;
      end

      case (state_ff)
         lzfd_pkg::ST_IDLE: begin
            if (req_accept) begin
               last_in = req_data.last_byte;
               if (consume) begin
                  case (phase_ff)
                     lzfd_pkg::PH_CTRL: begin
                        if (req_data.in_byte < lzfd_pkg::LIT_CTRL_LIMIT) begin
                           run_len_in      = 6'(req_data.in_byte) + 6'd1;
                           literal_left_in = 6'(req_data.in_byte) + 6'd1;
                           phase_in        = lzfd_pkg::PH_LIT;
                        end else begin
                           off_high_in = 5'(req_data.in_byte & lzfd_pkg::OFF_HIGH_MASK);
                           if (req_data.in_byte[7:5] == lzfd_pkg::EXT_LEN_CODE) begin
                              phase_in = lzfd_pkg::PH_EXT;
                           end else begin
                              ref_length_in = lzfd_pkg::LEN_W'(req_data.in_byte[7:5])
                                              + lzfd_pkg::LEN_W'(lzfd_pkg::MIN_REF_LEN);
                              phase_in      = lzfd_pkg::PH_OFF;
                           end
                        end
                     end
                     lzfd_pkg::PH_LIT: begin
                        // Park the literal at its final place in history
                        hist_we         = 1'b1;
                        hist_wa         = oc_ff[lzfd_pkg::HIST_AW-1:0]
                                          + lzfd_pkg::HIST_AW'(lit_idx);
                        hist_wd         = req_data.in_byte;
                        literal_left_in = literal_left_ff - 6'd1;
                        if (literal_left_ff == 6'd1) begin
                           phase_in    = lzfd_pkg::PH_CTRL;
                           copy_start  = 1'b1;
                           iss_left_in = lzfd_pkg::LEN_W'(run_len_ff);
                           rd_ptr_in   = oc_ff[lzfd_pkg::HIST_AW-1:0];
                        end
                     end
                     lzfd_pkg::PH_EXT: begin
                        ref_length_in = lzfd_pkg::LEN_W'(req_data.in_byte)
                                        + lzfd_pkg::LEN_W'(32'(lzfd_pkg::EXT_LEN_CODE)
                                                           + lzfd_pkg::MIN_REF_LEN);
                        phase_in      = lzfd_pkg::PH_OFF;
                     end
                     lzfd_pkg::PH_OFF: begin
                        phase_in = lzfd_pkg::PH_CTRL;
                        // Offset is off_raw + 1: reaching before the tile start halts
                        if (lzfd_pkg::COUNT_W'(off_raw) >= oc_ff) begin
                           halted_in = 1'b1;
                        end else begin
                           copy_start  = 1'b1;
                           iss_left_in = ref_length_ff;
                           rd_ptr_in   = oc_ff[lzfd_pkg::HIST_AW-1:0]
                                         - lzfd_pkg::HIST_AW'(off_raw)
                                         - lzfd_pkg::HIST_AW'(1);
                        end
                     end
                     default: begin
                        phase_in = lzfd_pkg::PH_CTRL;
                     end
                  endcase
               end
               if (copy_start) begin
                  state_in    = lzfd_pkg::ST_COPY;
                  iss_pos_in  = oc_ff;
                  rv_in       = 1'b0;
                  pack_cnt_in = '0;
               end else if (req_data.last_byte) begin
                  state_in = lzfd_pkg::ST_CLOSE;
               end
            end
         end

         lzfd_pkg::ST_COPY: begin
            if (go) begin
               if (issue) begin
                  hist_re     = 1'b1;
                  rd_ptr_in   = rd_ptr_ff + lzfd_pkg::HIST_AW'(1);
                  iss_left_in = iss_left_ff - lzfd_pkg::LEN_W'(1);
                  iss_pos_in  = iss_pos_ff + lzfd_pkg::COUNT_W'(1);
               end
               rv_in = issue;
               if (rv_ff) begin
                  // Write the copied byte back at the output position
                  hist_we = 1'b1;
                  hist_wa = oc_ff[lzfd_pkg::HIST_AW-1:0];
                  hist_wd = hist_rd;
                  oc_in   = oc_ff + lzfd_pkg::COUNT_W'(1);
                  pack_in = pack_word;
                  if (w_flush) begin
                     pack_cnt_in            = '0;
                     rsp_valid_in           = 1'b1;
                     rsp_data_in.out_bytes  = pack_word;
                     rsp_data_in.byte_count = 4'(pack_cnt_ff) + 4'd1;
                     rsp_data_in.run_last   = !issue && !last_ff;
                     rsp_data_in.tile_done  = 1'b0;
                     rsp_data_in.status     = lzfd_pkg::STATUS_COMPLETE;
                     rsp_data_in.produced   = oc_ff + lzfd_pkg::COUNT_W'(1);
                     if (!issue) begin
                        state_in = last_ff ? lzfd_pkg::ST_CLOSE : lzfd_pkg::ST_IDLE;
                     end
                  end else begin
                     pack_cnt_in = pack_cnt_ff + lzfd_pkg::LANE_W'(1);
                  end
               end
            end
         end

         lzfd_pkg::ST_CLOSE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_bytes  = '0;
               rsp_data_in.byte_count = 4'd0;
               rsp_data_in.run_last   = 1'b1;
               rsp_data_in.tile_done  = 1'b1;
               if (halted_ff) begin
                  rsp_data_in.status = lzfd_pkg::STATUS_BAD_OFFSET;
               end else if (oc_ff >= lim_ff) begin
                  rsp_data_in.status = lzfd_pkg::STATUS_COMPLETE;
               end else begin
                  rsp_data_in.status = lzfd_pkg::STATUS_SHORT;
               end
               rsp_data_in.produced = oc_ff;
               // Clear per-tile state; keep the limit and history
               phase_in        = lzfd_pkg::PH_CTRL;
               run_len_in      = '0;
               literal_left_in = '0;
               ref_length_in   = '0;
               off_high_in     = '0;
               oc_in           = '0;
               halted_in       = 1'b0;
               state_in        = lzfd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lzfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff          <= lzfd_pkg::TILE_BYTES_RESET;
         state_ff        <= lzfd_pkg::ST_IDLE;
         phase_ff        <= lzfd_pkg::PH_CTRL;
         run_len_ff      <= '0;
         literal_left_ff <= '0;
         ref_length_ff   <= '0;
         off_high_ff     <= '0;
         oc_ff           <= '0;
         halted_ff       <= 1'b0;
         last_ff         <= 1'b0;
         iss_left_ff     <= '0;
         iss_pos_ff      <= '0;
         rv_ff           <= 1'b0;
         pack_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         lim_ff          <= lim_in;
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         run_len_ff      <= run_len_in;
         literal_left_ff <= literal_left_in;
         ref_length_ff   <= ref_length_in;
         off_high_ff     <= off_high_in;
         oc_ff           <= oc_in;
         halted_ff       <= halted_in;
         last_ff         <= last_in;
         iss_left_ff     <= iss_left_in;
         iss_pos_ff      <= iss_pos_in;
         rv_ff           <= rv_in;
         pack_cnt_ff     <= pack_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      pack_ff     <= pack_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A closing result carries no bytes and ends the request's results
   a_close_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.tile_done) |->
         (rsp_data.byte_count == 4'd0) && rsp_data.run_last)
      else $error("closing result carries data or lacks run_last");

   // A data result carries between one and eight bytes
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.tile_done) |->
         (rsp_data.byte_count != 4'd0) && (rsp_data.byte_count <= 4'd8))
      else $error("data result byte count out of range");

   // The read issue position runs exactly one byte ahead while a read is in flight
   a_issue_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzfd_pkg::ST_COPY) |->
         (iss_pos_ff == oc_ff + lzfd_pkg::COUNT_W'(rv_ff)))
      else $error("copy engine issue position out of step with output count");

   // The copy engine never writes output beyond the tile limit
   a_copy_limit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lzfd_pkg::ST_COPY) && hist_we) |-> (oc_ff < lim_ff))
      else $error("copy engine wrote past the tile limit");
`endif

endmodule
